// ===== design/ssot_pkg.sv =====
`timescale 1ns / 1ps
// ssot_pkg: shared types and constants for the sphere overlap tester
// depends on nothing; used by the channel interfaces and the top level

package ssot_pkg;

    // fixed field geometry
    localparam int FIELD_BITS = 48;
    localparam int RAD_BITS   = 16;
    localparam int AXIS_BITS  = 16;
    localparam int AXIS_FRAC  = 14;

    // collider kind codes on req_type
    localparam logic [1:0] REQ_SPHERE = 2'd0;
    localparam logic [1:0] REQ_BOX    = 2'd1;

    // test carried down the pipeline
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SPHERE,
        MODE_BOX
    } mode_t;

    // request word
    typedef struct packed {
        logic [1:0]            req_type;
        logic                  same_object;
        logic [FIELD_BITS-1:0] sphere_center;
        logic [RAD_BITS-1:0]   sphere_radius;
        logic [FIELD_BITS-1:0] other_center;
        logic [RAD_BITS-1:0]   other_radius;
        logic [FIELD_BITS-1:0] half_extents;
        logic [FIELD_BITS-1:0] box_axis_u;
        logic [FIELD_BITS-1:0] box_axis_v;
        logic [FIELD_BITS-1:0] box_axis_w;
    } req_t;

    // response word
    typedef struct packed {
        logic hit;
    } rsp_t;

endpackage

// ===== design/ssot_req_if.sv =====
`timescale 1ns / 1ps
// ssot_req_if: valid/ready channel carrying one overlap request word
// depends on ssot_pkg for the request word type

interface ssot_req_if;
    logic            valid;
    logic            ready;
    ssot_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ssot_rsp_if.sv =====
`timescale 1ns / 1ps
// ssot_rsp_if: valid/ready channel carrying one overlap result word
// depends on ssot_pkg for the result word type

interface ssot_rsp_if;
    logic            valid;
    logic            ready;
    ssot_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/sphere_sphere_obb_overlap_test.sv =====
`timescale 1ns / 1ps
// sphere_sphere_obb_overlap_test: six stage pipelined sphere/sphere and sphere/box test
// depends on ssot_pkg, ssot_req_if and ssot_rsp_if
//
// usage
//   req carries one test per word: the own sphere and the other collider (sphere or
//   oriented box). rsp returns one word per request, in order, with the hit bit.
//   self tests and unsupported kinds answer hit = 0.
// pipeline
//   one word enters per cycle while the output is not stalled. the pipeline is
//   six register stages: lane differences, the multiplier bank (squares, nine axis
//   products, bound square), sums, clamp against the half extents, squaring of the
//   excess, final sum and compare.
// reset
//   rst_n clears every stage valid bit; the pipeline comes up empty and ready.
// stall
//   while the output word waits and rsp.ready is low, all stages hold together and
//   req.ready drops; bubbles in the pipeline never hold anything back because the
//   stages move whenever the output register is empty or being taken.

module sphere_sphere_obb_overlap_test #(
    parameter int COORD_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    ssot_req_if.sink       req,
    ssot_rsp_if.source     rsp
);

    localparam int CB        = COORD_BITS;
    localparam int RB        = ssot_pkg::RAD_BITS;
    localparam int AB        = ssot_pkg::AXIS_BITS;
    localparam int AF        = ssot_pkg::AXIS_FRAC;
    localparam int PAD_W     = (3 * CB > ssot_pkg::FIELD_BITS) ? 3 * CB : ssot_pkg::FIELD_BITS;
    localparam int D_W       = CB + 1;
    localparam int SQ_W      = 2 * D_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int PROD_W    = D_W + AB;
    localparam int P_W       = PROD_W + 2;
    localparam int R_W       = RB + AF;
    localparam int X_W       = (P_W > R_W) ? P_W : R_W;
    localparam int BND_W     = 2 * (RB + 1);
    localparam int SCMP_W    = (DIST_W > BND_W) ? DIST_W : BND_W;
    localparam int ESQ_W     = 2 * R_W;
    localparam int ESUM_W    = ESQ_W + 2;
    localparam int BOX_SHIFT = 2 * AF;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic [2:0][D_W-1:0]         diff;
        logic [2:0][CB-1:0]          half;
        logic [2:0][2:0][AB-1:0]     axis;
        logic [RB:0]                 bnd;
    } s1_t;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic [2:0][SQ_W-1:0]        sq;
        logic [2:0][2:0][PROD_W-1:0] prod;
        logic [2:0][CB-1:0]          half;
        logic [RB:0]                 bnd;
        logic [BND_W-1:0]            bnd_sq;
    } s2_t;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic [DIST_W-1:0]           dsq;
        logic [2:0][P_W-1:0]         p;
        logic [2:0][CB-1:0]          half;
        logic [RB:0]                 bnd;
        logic [BND_W-1:0]            bnd_sq;
    } s3_t;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic                        sph_hit;
        logic                        over;
        logic [2:0][R_W-1:0]         e;
        logic [BND_W-1:0]            bnd_sq;
    } s4_t;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic                        sph_hit;
        logic                        over;
        logic [2:0][ESQ_W-1:0]       esq;
        logic [BND_W-1:0]            bnd_sq;
    } s5_t;

    typedef struct packed {
        ssot_pkg::mode_t             mode;
        logic                        hit;
    } s6_t;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic adv;

    // signed coordinate lane; bits above the 48-bit field read as zero
    function automatic logic [CB-1:0] coord_lane(input logic [ssot_pkg::FIELD_BITS-1:0] v,
                                                 input int k);
        logic [PAD_W-1:0] pad;
        pad = PAD_W'(v);
        return pad[k*CB +: CB];
    endfunction

    // whole pipeline moves unless the output word is stuck
    assign adv       = !s6_valid_reg || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = s6_valid_reg;
    assign rsp.data.hit = s6_reg.hit;

    // stage 1: decode the test, centre differences, radius bound
    always_comb
    begin
        logic signed [CB-1:0] ca;
        logic signed [CB-1:0] cb;
        s1_next.mode = ssot_pkg::MODE_NONE;
        if (!req.data.same_object)
        begin
            unique case (req.data.req_type)
                ssot_pkg::REQ_SPHERE: s1_next.mode = ssot_pkg::MODE_SPHERE;
                ssot_pkg::REQ_BOX:    s1_next.mode = ssot_pkg::MODE_BOX;
                default:              s1_next.mode = ssot_pkg::MODE_NONE;
            endcase
        end
        for (int k = 0; k < 3; k++)
        begin
            ca = coord_lane(req.data.sphere_center, k);
            cb = coord_lane(req.data.other_center, k);
            s1_next.diff[k]    = D_W'(ca) - D_W'(cb);
            s1_next.half[k]    = coord_lane(req.data.half_extents, k);
            s1_next.axis[0][k] = req.data.box_axis_u[k*AB +: AB];
            s1_next.axis[1][k] = req.data.box_axis_v[k*AB +: AB];
            s1_next.axis[2][k] = req.data.box_axis_w[k*AB +: AB];
        end
        if (s1_next.mode == ssot_pkg::MODE_SPHERE)
            s1_next.bnd = (RB+1)'(req.data.sphere_radius) + (RB+1)'(req.data.other_radius);
        else if (s1_next.mode == ssot_pkg::MODE_BOX)
            s1_next.bnd = {1'b0, req.data.sphere_radius};
        else
            s1_next.bnd = '0;
    end

    // stage 2: multiplier bank
    always_comb
    begin
        logic signed [D_W-1:0] d;
        logic signed [AB-1:0]  ax;
        s2_next.mode   = s1_reg.mode;
        s2_next.half   = s1_reg.half;
        s2_next.bnd    = s1_reg.bnd;
        s2_next.bnd_sq = BND_W'(s1_reg.bnd) * BND_W'(s1_reg.bnd);
        for (int k = 0; k < 3; k++)
        begin
            d = s1_reg.diff[k];
            s2_next.sq[k] = SQ_W'(d) * SQ_W'(d);
            for (int j = 0; j < 3; j++)
            begin
                ax = s1_reg.axis[j][k];
                s2_next.prod[j][k] = PROD_W'(d) * PROD_W'(ax);
            end
        end
    end

    // stage 3: squared distance and axis projections
    always_comb
    begin
        logic signed [PROD_W-1:0] pr;
        logic signed [P_W-1:0]    acc;
        s3_next.mode   = s2_reg.mode;
        s3_next.half   = s2_reg.half;
        s3_next.bnd    = s2_reg.bnd;
        s3_next.bnd_sq = s2_reg.bnd_sq;
        s3_next.dsq    = DIST_W'(s2_reg.sq[0]) + DIST_W'(s2_reg.sq[1])
                       + DIST_W'(s2_reg.sq[2]);
        for (int j = 0; j < 3; j++)
        begin
            acc = '0;
            for (int k = 0; k < 3; k++)
            begin
                pr  = s2_reg.prod[j][k];
                acc = acc + P_W'(pr);
            end
            s3_next.p[j] = acc;
        end
    end

    // stage 4: sphere compare, excess beyond each half extent
    always_comb
    begin
        logic signed [P_W-1:0] pv;
        logic [X_W-1:0]        absp;
        logic [X_W-1:0]        h;
        logic [X_W-1:0]        r;
        logic [X_W-1:0]        ex;
        s4_next.mode    = s3_reg.mode;
        s4_next.bnd_sq  = s3_reg.bnd_sq;
        s4_next.sph_hit = SCMP_W'(s3_reg.dsq) <= SCMP_W'(s3_reg.bnd_sq);
        s4_next.over    = 1'b0;
        r = X_W'({s3_reg.bnd[RB-1:0], {AF{1'b0}}});
        for (int j = 0; j < 3; j++)
        begin
            pv   = s3_reg.p[j];
            absp = pv[P_W-1] ? X_W'(P_W'(-pv)) : X_W'(P_W'(pv));
            h    = X_W'({s3_reg.half[j], {AF{1'b0}}});
            ex   = (absp > h) ? absp - h : '0;
            if (ex > r)
                s4_next.over = 1'b1;
            s4_next.e[j] = ex[R_W-1:0];
        end
    end

    // stage 5: square the excess
    always_comb
    begin
        s5_next.mode    = s4_reg.mode;
        s5_next.sph_hit = s4_reg.sph_hit;
        s5_next.over    = s4_reg.over;
        s5_next.bnd_sq  = s4_reg.bnd_sq;
        for (int j = 0; j < 3; j++)
            s5_next.esq[j] = ESQ_W'(s4_reg.e[j]) * ESQ_W'(s4_reg.e[j]);
    end

    // stage 6: box compare and result select
    always_comb
    begin
        logic [ESUM_W-1:0] esum;
        esum = ESUM_W'(s5_reg.esq[0]) + ESUM_W'(s5_reg.esq[1]) + ESUM_W'(s5_reg.esq[2]);
        s6_next.mode = s5_reg.mode;
        case (s5_reg.mode)
            ssot_pkg::MODE_SPHERE: s6_next.hit = s5_reg.sph_hit;
            ssot_pkg::MODE_BOX:
                s6_next.hit = !s5_reg.over &&
                    (esum <= ESUM_W'({s5_reg.bnd_sq[2*RB-1:0], {BOX_SHIFT{1'b0}}}));
            default:               s6_next.hit = 1'b0;
        endcase
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    // an accepted word always lands in stage 1
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted word did not enter stage 1");

    // self tests and unsupported kinds never report a hit
    a_none_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (s6_valid_reg && s6_reg.mode == ssot_pkg::MODE_NONE) |-> !s6_reg.hit)
        else $error("hit reported for a self test or unsupported kind");

    // one axis beyond the radius rules out a box hit
    a_over_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s5_valid_reg && s5_reg.mode == ssot_pkg::MODE_BOX && s5_reg.over)
        |=> !s6_reg.hit)
        else $error("box hit despite an axis beyond the radius");

    // coincident sphere centres always overlap
    a_same_center_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_valid_reg && s3_reg.mode == ssot_pkg::MODE_SPHERE && s3_reg.dsq == '0)
        |=> s4_reg.sph_hit)
        else $error("coincident sphere centres reported as no overlap");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for sphere_sphere_obb_overlap_test, in-order hit prediction
// depends on ssot_pkg, ssot_req_if, ssot_rsp_if and the top level of the tester

module testbench;

    localparam int COORD_W      = 16;
    localparam int PHASE_ITEMS  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // kinds that the tester must refuse
    localparam logic [1:0] REQ_OTHER    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // q1.14 axis lane values
    localparam logic signed [15:0] AX_ONE  = 16'sd16384;
    localparam logic signed [15:0] AX_DIAG = 16'sd11585;

    logic clk;
    logic rst_n;

    ssot_req_if req_ch ();
    ssot_rsp_if rsp_ch ();

    sphere_sphere_obb_overlap_test #(
        .COORD_BITS(COORD_W)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    ssot_pkg::req_t req_backlog[$];
    bit             hit_expect[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    int mismatches;
    int n_sphere, n_box, n_self, n_odd;
    int n_words, n_hits;

    // signed lane of a packed coordinate field
    function automatic longint coord_at(logic [47:0] f, int k);
        logic signed [COORD_W-1:0] v;
        v = f[k*COORD_W +: COORD_W];
        return longint'(v);
    endfunction

    // signed lane of a packed axis field
    function automatic longint axis_at(logic [47:0] f, int k);
        logic signed [ssot_pkg::AXIS_BITS-1:0] v;
        v = f[k*ssot_pkg::AXIS_BITS +: ssot_pkg::AXIS_BITS];
        return longint'(v);
    endfunction

    // squared centre distance against squared radius sum
    function automatic bit sphere_pair_hit(ssot_pkg::req_t r);
        longint d;
        longint dsq;
        longint rs;
        dsq = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = coord_at(r.sphere_center, k) - coord_at(r.other_center, k);
            dsq += d * d;
        end
        rs = longint'(r.sphere_radius) + longint'(r.other_radius);
        return dsq <= rs * rs;
    endfunction

    // project offset on box axes, clamp to half extents, compare excess in q.14
    function automatic bit sphere_box_hit(ssot_pkg::req_t r);
        longint diff[3];
        logic [47:0] axis[3];
        longint p, h, c, e, rad, dsq;
        axis[0] = r.box_axis_u;
        axis[1] = r.box_axis_v;
        axis[2] = r.box_axis_w;
        rad = longint'(r.sphere_radius) << ssot_pkg::AXIS_FRAC;
        dsq = 0;
        for (int k = 0; k < 3; k++)
            diff[k] = coord_at(r.sphere_center, k) - coord_at(r.other_center, k);
        for (int j = 0; j < 3; j++)
        begin
            p = 0;
            h = longint'(r.half_extents[j*COORD_W +: COORD_W]) << ssot_pkg::AXIS_FRAC;
            for (int k = 0; k < 3; k++)
                p += diff[k] * axis_at(axis[j], k);
            c = (p > h) ? h : ((p < -h) ? -h : p);
            e = p - c;
            if (e < 0)
                e = -e;
            if (e > rad)
                return 1'b0;
            dsq += e * e;
        end
        return dsq <= rad * rad;
    endfunction

    function automatic bit overlap_hit(ssot_pkg::req_t r);
        if (r.same_object)
            return 1'b0;
        case (r.req_type)
            ssot_pkg::REQ_SPHERE: return sphere_pair_hit(r);
            ssot_pkg::REQ_BOX:    return sphere_box_hit(r);
            default:              return 1'b0;
        endcase
    endfunction

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // random request: mostly near pairs with sane boxes, some raw noise
    function automatic ssot_pkg::req_t random_request();
        ssot_pkg::req_t r;
        int pick;
        int s;
        int step;
        r = '0;
        pick = $urandom_range(0, 99);
        r.same_object = ($urandom_range(0, 9) == 0);
        if (pick >= 88)
        begin
            r.req_type      = 2'($urandom_range(0, 3));
            r.sphere_center = rand48();
            r.sphere_radius = 16'($urandom);
            r.other_center  = rand48();
            r.other_radius  = 16'($urandom);
            r.half_extents  = rand48();
            r.box_axis_u    = rand48();
            r.box_axis_v    = rand48();
            r.box_axis_w    = rand48();
            return r;
        end
        if (pick < 40)
            r.req_type = ssot_pkg::REQ_SPHERE;
        else if (pick < 80)
            r.req_type = ssot_pkg::REQ_BOX;
        else
            r.req_type = ($urandom_range(0, 1) != 0) ? REQ_OTHER : REQ_RESERVED;
        // other centre close to the sphere so that hits and misses both occur
        r.sphere_center = rand48();
        for (int k = 0; k < 3; k++)
        begin
            step = $urandom_range(0, 2047) - 1024;
            r.other_center[k*COORD_W +: COORD_W] = r.sphere_center[k*COORD_W +: COORD_W]
                                                 + 16'(step);
            r.half_extents[k*COORD_W +: COORD_W] = 16'($urandom_range(0, 511));
        end
        r.sphere_radius = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 1023));
        r.other_radius  = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 1023));
        // box orientation: signed axis permutation, 45 degree turn, or raw lanes
        case ($urandom_range(0, 3))
            0, 1:
            begin
                s = $urandom_range(0, 2);
                r.box_axis_u[s*16 +: 16] = ($urandom_range(0, 1) != 0) ? AX_ONE : -AX_ONE;
                r.box_axis_v[((s+1)%3)*16 +: 16] =
                    ($urandom_range(0, 1) != 0) ? AX_ONE : -AX_ONE;
                r.box_axis_w[((s+2)%3)*16 +: 16] =
                    ($urandom_range(0, 1) != 0) ? AX_ONE : -AX_ONE;
            end
            2:
            begin
                r.box_axis_u = pack3(AX_DIAG, AX_DIAG, 16'd0);
                r.box_axis_v = pack3(-AX_DIAG, AX_DIAG, 16'd0);
                r.box_axis_w = pack3(16'd0, 16'd0, AX_ONE);
            end
            default:
            begin
                r.box_axis_u = rand48();
                r.box_axis_v = rand48();
                r.box_axis_w = rand48();
            end
        endcase
        return r;
    endfunction

    // hand-picked requests: touching, off by one, self, refused kinds, range edges
    task automatic queue_directed();
        ssot_pkg::req_t r;
        // sphere pair at a 3-4-5 spacing, exactly touching then one short
        r = '0;
        r.req_type      = ssot_pkg::REQ_SPHERE;
        r.other_center  = pack3(16'd768, 16'd1024, 16'd0);
        r.sphere_radius = 16'd640;
        r.other_radius  = 16'd640;
        req_backlog.push_back(r);
        r.other_radius = 16'd639;
        req_backlog.push_back(r);
        r.other_radius = 16'd640;
        r.same_object  = 1'b1;
        req_backlog.push_back(r);
        r.same_object = 1'b0;
        r.req_type    = REQ_OTHER;
        req_backlog.push_back(r);
        r.req_type = REQ_RESERVED;
        req_backlog.push_back(r);
        // opposite corners of the coordinate range
        r = '0;
        r.req_type      = ssot_pkg::REQ_SPHERE;
        r.sphere_center = pack3(16'h7fff, 16'h7fff, 16'h7fff);
        r.other_center  = pack3(16'h8000, 16'h8000, 16'h8000);
        r.sphere_radius = 16'hffff;
        r.other_radius  = 16'hffff;
        req_backlog.push_back(r);
        r.sphere_radius = 16'd0;
        r.other_radius  = 16'd0;
        req_backlog.push_back(r);
        // coincident centres with zero radii
        r = '0;
        req_backlog.push_back(r);
        // axis aligned box, centre inside, face touching, face just missed
        r = '0;
        r.req_type      = ssot_pkg::REQ_BOX;
        r.box_axis_u    = pack3(AX_ONE, 16'd0, 16'd0);
        r.box_axis_v    = pack3(16'd0, AX_ONE, 16'd0);
        r.box_axis_w    = pack3(16'd0, 16'd0, AX_ONE);
        r.half_extents  = pack3(16'd256, 16'd256, 16'd256);
        r.sphere_radius = 16'd1;
        req_backlog.push_back(r);
        r.sphere_center = pack3(16'd512, 16'd0, 16'd0);
        r.sphere_radius = 16'd256;
        req_backlog.push_back(r);
        r.sphere_radius = 16'd255;
        req_backlog.push_back(r);
        // corner: each axis within the radius but the sum outside, then inside
        r.sphere_center = pack3(16'd512, 16'd512, 16'd512);
        r.sphere_radius = 16'd443;
        req_backlog.push_back(r);
        r.sphere_radius = 16'd444;
        req_backlog.push_back(r);
        r.same_object = 1'b1;
        req_backlog.push_back(r);
        r.same_object = 1'b0;
        // box turned 45 degrees about z
        r.box_axis_u    = pack3(AX_DIAG, AX_DIAG, 16'd0);
        r.box_axis_v    = pack3(-AX_DIAG, AX_DIAG, 16'd0);
        r.sphere_center = pack3(16'd0, 16'd600, 16'd0);
        r.sphere_radius = 16'd200;
        req_backlog.push_back(r);
        // axes far from unit length at the lane extremes, full range centres
        r.box_axis_u    = pack3(16'h8000, 16'h8000, 16'h8000);
        r.box_axis_v    = pack3(16'h7fff, 16'h7fff, 16'h7fff);
        r.box_axis_w    = pack3(16'h8000, 16'h7fff, 16'h0000);
        r.sphere_center = pack3(16'h7fff, 16'h7fff, 16'h7fff);
        r.other_center  = pack3(16'h8000, 16'h8000, 16'h8000);
        r.half_extents  = pack3(16'hffff, 16'hffff, 16'hffff);
        r.sphere_radius = 16'hffff;
        req_backlog.push_back(r);
        r.half_extents  = '0;
        r.sphere_radius = 16'd0;
        req_backlog.push_back(r);
        // every bit set, then a degenerate all-zero box
        r = '1;
        r.req_type    = ssot_pkg::REQ_BOX;
        r.same_object = 1'b0;
        req_backlog.push_back(r);
        r = '0;
        r.req_type = ssot_pkg::REQ_BOX;
        req_backlog.push_back(r);
    endtask

    // hold off until every word sent has come back
    task automatic wait_quiet();
        while (req_backlog.size() != 0 || hit_expect.size() != 0 || req_ch.valid)
            @(posedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // request driver and prediction at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                hit_expect.push_back(overlap_hit(req_ch.data));
                if (req_ch.data.same_object)
                    n_self++;
                else
                    case (req_ch.data.req_type)
                        ssot_pkg::REQ_SPHERE: n_sphere++;
                        ssot_pkg::REQ_BOX:    n_box++;
                        default:              n_odd++;
                    endcase
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_ch.data  <= req_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        bit want_hit;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_words++;
                if (rsp_ch.data.hit === 1'b1)
                    n_hits++;
                if (hit_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with no request pending, hit=%b",
                                 $realtime, rsp_ch.data.hit);
                end
                else
                begin
                    want_hit = hit_expect.pop_front();
                    if (rsp_ch.data.hit !== want_hit)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: hit mismatch on word %0d: expected %b, got %b",
                                     $realtime, n_words, want_hit, rsp_ch.data.hit);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus phases and verdict
    initial
    begin
        send_idle_pct = 19;
        recv_idle_pct = 60;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver often stalled
        queue_directed();
        for (int i = 0; i < PHASE_ITEMS; i++)
            req_backlog.push_back(random_request());
        wait_quiet();

        // sender sparse, receiver mostly ready
        send_idle_pct = 60;
        recv_idle_pct = 19;
        for (int i = 0; i < PHASE_ITEMS; i++)
            req_backlog.push_back(random_request());
        wait_quiet();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
            req_backlog.push_back(random_request());
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d sphere pairs, %0d boxes, %0d self tests, %0d refused kinds",
                 n_sphere, n_box, n_self, n_odd);
        $display("results: %0d words checked, %0d hits, %0d mismatches",
                 n_words, n_hits, mismatches);
        if (mismatches == 0 && hit_expect.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
